FILE: src/nbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbg_pkg
// Shared constants and types for the n-body gravity derivative block.
// ----------------------------------------------------------------------------
package nbg_pkg;

    localparam int MAX_BODIES = 32;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);
    localparam int BODY_W     = 128;
    localparam int ACC_W      = 40;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTRAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR    = 1'b1;

    localparam logic [63:0] R2_SKIP_MAX  = 64'd429496;
    localparam logic [63:0] STRENGTH_DIV = 64'd100;

    // quotient widths of the three divisions of one component, and square root steps
    localparam int Q_T    = 17;
    localparam int Q_U    = 37;
    localparam int Q_C    = 31;
    localparam int SQRT_N = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KRD,
        ST_KLAT,
        ST_JRD,
        ST_SETUP,
        ST_SQX,
        ST_SQY,
        ST_CHK,
        ST_SQRT,
        ST_DIVT,
        ST_MULU,
        ST_DIVU,
        ST_DIVC,
        ST_NEXT,
        ST_EMIT
    } state_t;

endpackage

FILE: src/nbody_gravity_derivative.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbody_gravity_derivative
// Loads bodies, then emits position rate and gravity acceleration per body.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  in      | in_valid in_ready pos_x vel_x pos_y vel_y        | input item
//          | last_body                                       |
//  out     | out_valid out_ready body_index rate_x accel_x    | result item
//          | rate_y accel_y last_result                      |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data           | register write
//
//  Loading accepts one body per cycle while idle. After the last body, for each
//  body k and each pull term one shared subtractor runs a 32-step square
//  root and three restoring divisions (17, 37, 31 steps) per axis; a term
//  can be skipped at setup, or after the distance check as too close.
//  Reset clears control state and both strength registers.
//  A stalled result holds the sequencer in its emit state until it is transferred.
// ----------------------------------------------------------------------------
module nbody_gravity_derivative (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [31:0]            pos_x,
    input  logic signed [31:0]            vel_x,
    input  logic signed [31:0]            pos_y,
    input  logic signed [31:0]            vel_y,
    input  logic                          last_body,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [4:0]                    body_index,
    output logic signed [31:0]            rate_x,
    output logic signed [31:0]            accel_x,
    output logic signed [31:0]            rate_y,
    output logic signed [31:0]            accel_y,
    output logic                          last_result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nbg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);

    nbg_pkg::state_t state_reg, state_next;

    logic signed [7:0]            central_reg, pair_reg;
    logic [nbg_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [nbg_pkg::CNT_W-1:0]    n_reg, n_next;
    logic [nbg_pkg::CNT_W-1:0]    k_reg, k_next;
    logic [nbg_pkg::CNT_W-1:0]    j_reg, j_next;
    logic                         cen_reg, cen_next;
    logic                         comp_reg, comp_next;
    logic [31:0]                  pkx_reg, pkx_next, pky_reg, pky_next;
    logic [31:0]                  vkx_reg, vkx_next, vky_reg, vky_next;
    logic [31:0]                  mx_reg, mx_next, my_reg, my_next;
    logic                         negx_reg, negx_next, negy_reg, negy_next;
    logic [7:0]                   as_reg, as_next;
    logic [63:0]                  r2_reg, r2_next;
    logic [63:0]                  work_reg, work_next;
    logic [63:0]                  sh_reg, sh_next;
    logic [63:0]                  bit_reg, bit_next;
    logic [63:0]                  dvs_reg, dvs_next;
    logic [31:0]                  root_reg, root_next;
    logic [16:0]                  t_reg, t_next;
    logic [5:0]                   cnt_reg, cnt_next;
    logic signed [nbg_pkg::ACC_W-1:0] accx_reg, accx_next, accy_reg, accy_next;

    logic                         ov_reg, ov_next;
    logic [4:0]                   oidx_reg, oidx_next;
    logic [31:0]                  orx_reg, orx_next, oax_reg, oax_next;
    logic [31:0]                  ory_reg, ory_next, oay_reg, oay_next;
    logic                         olast_reg, olast_next;

    logic                         ram_we;
    logic [nbg_pkg::IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [nbg_pkg::BODY_W-1:0]   ram_wdata, ram_rdata;

    logic [31:0]                  mul_a, mul_b;
    logic [63:0]                  mul_p;
    logic [63:0]                  sub_a, sub_b;
    logic [64:0]                  sub_d;
    logic                         sub_ge;

    logic                         in_xfer, out_free, sqrt_last, div_last;
    logic                         skip_term;
    logic [63:0]                  div_w2, div_q;
    logic signed [32:0]           dx, dy;
    logic [32:0]                  magx, magy;
    logic signed [7:0]            s_sel;
    logic [nbg_pkg::CNT_W-1:0]    jn0, jn1;

    function automatic logic [31:0] sat32(input logic signed [nbg_pkg::ACC_W-1:0] v);
        logic [nbg_pkg::ACC_W-32:0] top;
        top = v[nbg_pkg::ACC_W-1:31];
        if (v[nbg_pkg::ACC_W-1] == 1'b0 && top != '0)
        begin
            return 32'h7fff_ffff;
        end
        else if (v[nbg_pkg::ACC_W-1] == 1'b1 && top != '1)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    nbg_ram #(
        .WIDTH (nbg_pkg::BODY_W),
        .DEPTH (nbg_pkg::MAX_BODIES)
    ) u_body_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == nbg_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !ov_reg || out_ready;

    assign out_valid   = ov_reg;
    assign body_index  = oidx_reg;
    assign rate_x      = orx_reg;
    assign accel_x     = oax_reg;
    assign rate_y      = ory_reg;
    assign accel_y     = oay_reg;
    assign last_result = olast_reg;

    assign ram_we    = in_xfer && (count_reg < nbg_pkg::CNT_W'(nbg_pkg::MAX_BODIES));
    assign ram_waddr = count_reg[nbg_pkg::IDX_W-1:0];
    assign ram_wdata = {pos_x, pos_y, vel_x, vel_y};
    assign ram_raddr = (state_reg == nbg_pkg::ST_KRD) ? k_reg[nbg_pkg::IDX_W-1:0]
                                                      : j_reg[nbg_pkg::IDX_W-1:0];

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            nbg_pkg::ST_SQX:
            begin
                mul_a = mx_reg;
                mul_b = mx_reg;
            end
            nbg_pkg::ST_SQY:
            begin
                mul_a = my_reg;
                mul_b = my_reg;
            end
            default:
            begin
                mul_a = {24'd0, as_reg};
                mul_b = {15'd0, t_reg};
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // shared subtractor
    assign div_w2 = {work_reg[62:0], sh_reg[63]};
    always_comb
    begin
        if (state_reg == nbg_pkg::ST_SQRT)
        begin
            sub_a = work_reg;
            sub_b = sh_reg | bit_reg;
        end
        else
        begin
            sub_a = div_w2;
            sub_b = dvs_reg;
        end
    end
    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[64];
    assign div_q  = {sh_reg[62:0], sub_ge};

    assign sqrt_last = (cnt_reg == 6'(nbg_pkg::SQRT_N - 1));
    always_comb
    begin
        case (state_reg)
            nbg_pkg::ST_DIVT: div_last = (cnt_reg == 6'(nbg_pkg::Q_T - 1));
            nbg_pkg::ST_DIVU: div_last = (cnt_reg == 6'(nbg_pkg::Q_U - 1));
            nbg_pkg::ST_DIVC: div_last = (cnt_reg == 6'(nbg_pkg::Q_C - 1));
            default:          div_last = 1'b0;
        endcase
    end

    // term offset and strength
    always_comb
    begin
        if (cen_reg)
        begin
            dx    = 33'sd0 - 33'(signed'(pkx_reg));
            dy    = 33'sd0 - 33'(signed'(pky_reg));
            s_sel = central_reg;
        end
        else
        begin
            dx    = 33'(signed'(ram_rdata[127:96])) - 33'(signed'(pkx_reg));
            dy    = 33'(signed'(ram_rdata[95:64])) - 33'(signed'(pky_reg));
            s_sel = pair_reg;
        end
        magx = dx[32] ? 33'(-dx) : 33'(dx);
        magy = dy[32] ? 33'(-dy) : 33'(dy);
        skip_term = (s_sel == 8'sd0) || magx[32] || magx[31] || magy[32] || magy[31];
    end

    assign jn0 = cen_reg ? '0 : j_reg + 1'b1;
    assign jn1 = (jn0 == k_reg) ? jn0 + 1'b1 : jn0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nbg_pkg::ST_IDLE:
            begin
                if (in_xfer && last_body)
                begin
                    state_next = nbg_pkg::ST_KRD;
                end
            end
            nbg_pkg::ST_KRD:   state_next = nbg_pkg::ST_KLAT;
            nbg_pkg::ST_KLAT:  state_next = nbg_pkg::ST_SETUP;
            nbg_pkg::ST_JRD:   state_next = nbg_pkg::ST_SETUP;
            nbg_pkg::ST_SETUP: state_next = skip_term ? nbg_pkg::ST_NEXT : nbg_pkg::ST_SQX;
            nbg_pkg::ST_SQX:   state_next = nbg_pkg::ST_SQY;
            nbg_pkg::ST_SQY:   state_next = nbg_pkg::ST_CHK;
            nbg_pkg::ST_CHK:
            begin
                state_next = (r2_reg <= nbg_pkg::R2_SKIP_MAX) ? nbg_pkg::ST_NEXT
                                                               : nbg_pkg::ST_SQRT;
            end
            nbg_pkg::ST_SQRT:
            begin
                if (sqrt_last)
                begin
                    state_next = nbg_pkg::ST_DIVT;
                end
            end
            nbg_pkg::ST_DIVT:
            begin
                if (div_last)
                begin
                    state_next = nbg_pkg::ST_MULU;
                end
            end
            nbg_pkg::ST_MULU:  state_next = nbg_pkg::ST_DIVU;
            nbg_pkg::ST_DIVU:
            begin
                if (div_last)
                begin
                    state_next = nbg_pkg::ST_DIVC;
                end
            end
            nbg_pkg::ST_DIVC:
            begin
                if (div_last)
                begin
                    state_next = comp_reg ? nbg_pkg::ST_NEXT : nbg_pkg::ST_DIVT;
                end
            end
            nbg_pkg::ST_NEXT:
            begin
                state_next = (jn1 >= n_reg) ? nbg_pkg::ST_EMIT : nbg_pkg::ST_JRD;
            end
            nbg_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (k_reg + 1'b1 == n_reg) ? nbg_pkg::ST_IDLE
                                                         : nbg_pkg::ST_KRD;
                end
            end
            default:           state_next = nbg_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        logic [nbg_pkg::ACC_W-1:0] a_ext;
        logic signed [nbg_pkg::ACC_W-1:0] acc_sel, acc_new;

        count_next = count_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        cen_next   = cen_reg;
        comp_next  = comp_reg;
        pkx_next   = pkx_reg;
        pky_next   = pky_reg;
        vkx_next   = vkx_reg;
        vky_next   = vky_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        negx_next  = negx_reg;
        negy_next  = negy_reg;
        as_next    = as_reg;
        r2_next    = r2_reg;
        work_next  = work_reg;
        sh_next    = sh_reg;
        bit_next   = bit_reg;
        dvs_next   = dvs_reg;
        root_next  = root_reg;
        t_next     = t_reg;
        cnt_next   = cnt_reg;
        accx_next  = accx_reg;
        accy_next  = accy_reg;
        ov_next    = ov_reg && !out_ready;
        oidx_next  = oidx_reg;
        orx_next   = orx_reg;
        oax_next   = oax_reg;
        ory_next   = ory_reg;
        oay_next   = oay_reg;
        olast_next = olast_reg;

        a_ext   = {{(nbg_pkg::ACC_W - 31){1'b0}}, div_q[30:0]};
        acc_sel = comp_reg ? accy_reg : accx_reg;
        if (comp_reg ? negy_reg : negx_reg)
        begin
            acc_new = acc_sel - signed'(a_ext);
        end
        else
        begin
            acc_new = acc_sel + signed'(a_ext);
        end

        case (state_reg)
            nbg_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (ram_we)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (last_body)
                    begin
                        n_next     = ram_we ? count_reg + 1'b1 : count_reg;
                        count_next = '0;
                        k_next     = '0;
                    end
                end
            end
            nbg_pkg::ST_KLAT:
            begin
                pkx_next  = ram_rdata[127:96];
                pky_next  = ram_rdata[95:64];
                vkx_next  = ram_rdata[63:32];
                vky_next  = ram_rdata[31:0];
                accx_next = '0;
                accy_next = '0;
                cen_next  = 1'b1;
            end
            nbg_pkg::ST_SETUP:
            begin
                mx_next   = {1'b0, magx[30:0]};
                my_next   = {1'b0, magy[30:0]};
                negx_next = s_sel[7] ^ dx[32];
                negy_next = s_sel[7] ^ dy[32];
                as_next   = s_sel[7] ? 8'(-s_sel) : 8'(s_sel);
            end
            nbg_pkg::ST_SQX:
            begin
                r2_next = mul_p;
            end
            nbg_pkg::ST_SQY:
            begin
                r2_next = r2_reg + mul_p;
            end
            nbg_pkg::ST_CHK:
            begin
                work_next = r2_reg;
                sh_next   = '0;
                bit_next  = 64'd1 << 62;
                cnt_next  = '0;
            end
            nbg_pkg::ST_SQRT:
            begin
                if (sub_ge)
                begin
                    work_next = sub_d[63:0];
                    sh_next   = (sh_reg >> 1) | bit_reg;
                end
                else
                begin
                    sh_next = sh_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (sqrt_last)
                begin
                    comp_next = 1'b0;
                    root_next = sh_next[31:0];
                    dvs_next  = {32'd0, sh_next[31:0]};
                    work_next = {32'd0, mx_reg} >> (nbg_pkg::Q_T - 16);
                    sh_next   = {32'd0, mx_reg} << (64 - nbg_pkg::Q_T + 16);
                    cnt_next  = '0;
                end
            end
            nbg_pkg::ST_DIVT,
            nbg_pkg::ST_DIVU,
            nbg_pkg::ST_DIVC:
            begin
                work_next = sub_ge ? sub_d[63:0] : div_w2;
                sh_next   = div_q;
                cnt_next  = cnt_reg + 1'b1;
                if (div_last)
                begin
                    cnt_next = '0;
                    case (state_reg)
                        nbg_pkg::ST_DIVT:
                        begin
                            t_next = div_q[16:0];
                        end
                        nbg_pkg::ST_DIVU:
                        begin
                            dvs_next  = nbg_pkg::STRENGTH_DIV;
                            work_next = {27'd0, div_q[36:0]} >> nbg_pkg::Q_C;
                            sh_next   = {27'd0, div_q[36:0]} << (64 - nbg_pkg::Q_C);
                        end
                        default:
                        begin
                            if (comp_reg)
                            begin
                                accy_next = acc_new;
                            end
                            else
                            begin
                                // y-axis division restarts from the stored root
                                accx_next = acc_new;
                                comp_next = 1'b1;
                                dvs_next  = {32'd0, root_reg};
                                work_next = {32'd0, my_reg} >> (nbg_pkg::Q_T - 16);
                                sh_next   = {32'd0, my_reg} << (64 - nbg_pkg::Q_T + 16);
                            end
                        end
                    endcase
                end
            end
            nbg_pkg::ST_MULU:
            begin
                dvs_next  = r2_reg;
                work_next = {mul_p[31:0], 32'd0} >> nbg_pkg::Q_U;
                sh_next   = {mul_p[31:0], 32'd0} << (64 - nbg_pkg::Q_U);
                cnt_next  = '0;
            end
            nbg_pkg::ST_NEXT:
            begin
                cen_next = 1'b0;
                j_next   = jn1;
            end
            nbg_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = k_reg[4:0];
                    orx_next   = vkx_reg;
                    ory_next   = vky_reg;
                    oax_next   = sat32(accx_reg);
                    oay_next   = sat32(accy_reg);
                    olast_next = (k_reg + 1'b1 == n_reg);
                    k_next     = k_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nbg_pkg::ST_IDLE;
            central_reg <= '0;
            pair_reg    <= '0;
            count_reg   <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
            j_reg       <= '0;
            cen_reg     <= 1'b0;
            comp_reg    <= 1'b0;
            cnt_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    nbg_pkg::CFG_CENTRAL: central_reg <= signed'(cfg_data);
                    nbg_pkg::CFG_PAIR:    pair_reg    <= signed'(cfg_data);
                    default:
                    begin
                    end
                endcase
            end
            count_reg <= count_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            cen_reg   <= cen_next;
            comp_reg  <= comp_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkx_reg   <= pkx_next;
        pky_reg   <= pky_next;
        vkx_reg   <= vkx_next;
        vky_reg   <= vky_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        negx_reg  <= negx_next;
        negy_reg  <= negy_next;
        as_reg    <= as_next;
        r2_reg    <= r2_next;
        work_reg  <= work_next;
        bit_reg   <= bit_next;
        t_reg     <= t_next;
        accx_reg  <= accx_next;
        accy_reg  <= accy_next;
        oidx_reg  <= oidx_next;
        orx_reg   <= orx_next;
        oax_reg   <= oax_next;
        ory_reg   <= ory_next;
        oay_reg   <= oay_next;
        olast_reg <= olast_next;
        root_reg  <= root_next;
        dvs_reg   <= dvs_next;
        sh_reg    <= sh_next;
    end

endmodule

FILE: src/nbg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module nbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/nbg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbg_checker
// Port-level checks for the n-body gravity derivative block.
// ----------------------------------------------------------------------------
module nbg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       last_body,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] body_index,
    input logic       last_result
);

    // a pending result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(body_index)
                                    && $stable(last_result))
    else $error("pending result changed");

    // the set closes on a last body
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_body |=> !in_ready)
    else $error("input taken while evaluating");

    // no loading while a set is still being emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> !in_ready)
    else $error("input open mid-set");

endmodule

bind nbody_gravity_derivative nbg_checker u_nbg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .last_body   (last_body),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .body_index  (body_index),
    .last_result (last_result)
);
